// File: src/cab_pkg.sv
// Shared types, widths and operation codes for the execute stage.
// No dependencies; imported by every module of the block.
`default_nettype none

package cab_pkg;

    localparam int WORD_W    = 16;
    localparam int REG_COUNT = 16;
    localparam int IDX_W     = $clog2(REG_COUNT);
    localparam int MODE_W    = 6;
    localparam int CNT_W     = $clog2(WORD_W);

    localparam int S_DATA_W  = 48;
    localparam int S_USER_W  = 6;
    localparam int M_DATA_W  = 40;

    localparam logic [MODE_W-1:0] OP_NOP = 6'd0;
    localparam logic [MODE_W-1:0] OP_LOD = 6'd1;
    localparam logic [MODE_W-1:0] OP_SWP = 6'd2;
    localparam logic [MODE_W-1:0] OP_ADD = 6'd3;
    localparam logic [MODE_W-1:0] OP_ADC = 6'd4;
    localparam logic [MODE_W-1:0] OP_SUB = 6'd5;
    localparam logic [MODE_W-1:0] OP_SBB = 6'd6;
    localparam logic [MODE_W-1:0] OP_INC = 6'd7;
    localparam logic [MODE_W-1:0] OP_DEC = 6'd8;
    localparam logic [MODE_W-1:0] OP_MUL = 6'd9;
    localparam logic [MODE_W-1:0] OP_DIV = 6'd10;
    localparam logic [MODE_W-1:0] OP_AND = 6'd11;
    localparam logic [MODE_W-1:0] OP_OR  = 6'd12;
    localparam logic [MODE_W-1:0] OP_XOR = 6'd13;
    localparam logic [MODE_W-1:0] OP_NOT = 6'd14;
    localparam logic [MODE_W-1:0] OP_NEG = 6'd15;
    localparam logic [MODE_W-1:0] OP_SHL = 6'd16;
    localparam logic [MODE_W-1:0] OP_SHR = 6'd17;
    localparam logic [MODE_W-1:0] OP_SAR = 6'd18;
    localparam logic [MODE_W-1:0] OP_JMP = 6'd19;
    localparam logic [MODE_W-1:0] OP_JE  = 6'd20;
    localparam logic [MODE_W-1:0] OP_JNE = 6'd21;
    localparam logic [MODE_W-1:0] OP_JZ  = 6'd22;
    localparam logic [MODE_W-1:0] OP_JNZ = 6'd23;
    localparam logic [MODE_W-1:0] OP_JL  = 6'd24;
    localparam logic [MODE_W-1:0] OP_JLE = 6'd25;
    localparam logic [MODE_W-1:0] OP_JG  = 6'd26;
    localparam logic [MODE_W-1:0] OP_JGE = 6'd27;
    localparam logic [MODE_W-1:0] OP_JB  = 6'd28;
    localparam logic [MODE_W-1:0] OP_JBE = 6'd29;
    localparam logic [MODE_W-1:0] OP_JA  = 6'd30;
    localparam logic [MODE_W-1:0] OP_JAE = 6'd31;
    localparam logic [MODE_W-1:0] OP_FOR = 6'd32;
    localparam logic [MODE_W-1:0] OP_BRK = 6'd33;

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] idx;
    } t_rf_rd;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] data;
    } t_rf_wr;

    typedef struct packed {
        logic              cout;
        logic              zero;
        logic [WORD_W-1:0] sum;
    } t_add_res;

endpackage

`default_nettype wire

// File: src/cab_addsub.sv
// Shared adder of the execute stage: sum, carry out and zero flag.
// Depends on cab_pkg.
`default_nettype none

module cab_addsub import cab_pkg::*; (
    input  wire logic [WORD_W-1:0] i_a,
    input  wire logic [WORD_W-1:0] i_b,
    input  wire logic              i_cin,
    output t_add_res               o_res
);

    logic [WORD_W:0] sum_w;

    assign sum_w       = {1'b0, i_a} + {1'b0, i_b} + {{WORD_W{1'b0}}, i_cin};
    assign o_res.sum   = sum_w[WORD_W-1:0];
    assign o_res.cout  = sum_w[WORD_W];
    assign o_res.zero  = (sum_w[WORD_W-1:0] == '0);

endmodule

`default_nettype wire

// File: src/cab_regfile.sv
// Register file: two registered read ports, one write port, per-entry
// valid bits so unwritten entries read zero after reset. Depends on cab_pkg.
`default_nettype none

module cab_regfile import cab_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  t_rf_rd                 i_rd0,
    input  t_rf_rd                 i_rd1,
    input  t_rf_wr                 i_wr,
    output logic [WORD_W-1:0]      o_rdata0,
    output logic [WORD_W-1:0]      o_rdata1
);

    logic [WORD_W-1:0]    mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_vld;
    logic [WORD_W-1:0]    r_rd0;
    logic [WORD_W-1:0]    r_rd1;
    logic                 r_hit0;
    logic                 r_hit1;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.idx] <= i_wr.data;
        end
        r_rd0 <= mem[i_rd0.idx];
        r_rd1 <= mem[i_rd1.idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_hit0 <= 1'b0;
            r_hit1 <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.idx] <= 1'b1;
            end
            r_hit0 <= i_rd0.ok && r_vld[i_rd0.idx];
            r_hit1 <= i_rd1.ok && r_vld[i_rd1.idx];
        end
    end

    assign o_rdata0 = r_hit0 ? r_rd0 : '0;
    assign o_rdata1 = r_hit1 ? r_rd1 : '0;

endmodule

`default_nettype wire

// File: src/cpu16_alu_branch_execute.sv
// Execute stage of a 16-bit register machine: sequencer around one shared adder.
// States in order: read b and c, read a, execute, an extra state for swap and counted loop,
// 16 steps for multiply and nonzero divide (none for divide by zero), then write-back.
// One instruction at a time; tready is low until the result is in the output register.
// Reset (synchronous, active low) clears registers to zero and the carry.
// Depends on cab_pkg, cab_addsub, cab_regfile.
`default_nettype none

module cpu16_alu_branch_execute import cab_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // operand_a [15:0], operand_b [31:16], operand_c [47:32]
    input  wire logic [S_DATA_W-1:0] i_s_axis_tdata,
    // mode [5:0]
    input  wire logic [S_USER_W-1:0] i_s_axis_tuser,
    output logic                     o_m_axis_tvalid,
    input  wire logic                i_m_axis_tready,
    // write_enable [0], write_index [4:1], write_value [20:5], branch_taken [21],
    // branch_target [37:22], carry_flag [38], halt [39]
    output logic [M_DATA_W-1:0]      o_m_axis_tdata
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RDBC = 4'd1;
    localparam logic [3:0] S_RDA  = 4'd2;
    localparam logic [3:0] S_EXEC = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_DIV  = 4'd5;
    localparam logic [3:0] S_FOR  = 4'd6;
    localparam logic [3:0] S_SWP  = 4'd7;
    localparam logic [3:0] S_WB   = 4'd8;

    logic [3:0]          r_state, n_state;
    logic [MODE_W-1:0]   r_mode;
    logic [WORD_W-1:0]   r_a, r_b, r_c, r_x, r_y;
    logic [WORD_W-1:0]   r_acc, r_quo;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_carry;
    logic                r_wen, r_take, r_halt;
    logic [IDX_W-1:0]    r_widx;
    logic [WORD_W-1:0]   r_wval, r_tgt;
    logic                r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;

    logic              s_acc, out_load;
    logic              a_ok, b_ok, c_ok, c_big;
    logic [WORD_W-1:0] ra, rd0, rd1;
    logic [WORD_W-1:0] add_a, add_b;
    logic              add_cin;
    t_add_res          add_res;
    t_rf_rd            rf_rd0, rf_rd1;
    t_rf_wr            rf_wr;
    logic              lt, eq, cond;
    logic [WORD_W-1:0] div_sh, shf;
    logic              div_ge;
    logic [WORD_W-1:0] sign_bit;

    assign sign_bit = {1'b1, {(WORD_W-1){1'b0}}};
    assign s_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign out_load = (r_state == S_WB) && (!r_out_valid || i_m_axis_tready);
    assign a_ok     = r_a < WORD_W'(REG_COUNT);
    assign b_ok     = r_b < WORD_W'(REG_COUNT);
    assign c_ok     = r_c < WORD_W'(REG_COUNT);
    assign c_big    = r_c >= WORD_W'(WORD_W);
    assign ra       = rd0;

    always_comb begin
        rf_rd0 = '{ok: b_ok, idx: r_b[IDX_W-1:0]};
        rf_rd1 = '{ok: c_ok, idx: r_c[IDX_W-1:0]};
        if (r_state == S_RDA) begin
            rf_rd0 = '{ok: a_ok, idx: r_a[IDX_W-1:0]};
        end
        rf_wr = '{en: 1'b0, idx: r_a[IDX_W-1:0], data: r_wval};
        if (r_state == S_WB) begin
            rf_wr.en = out_load && r_wen;
        end else if (r_state == S_SWP) begin
            rf_wr = '{en: b_ok, idx: r_b[IDX_W-1:0], data: r_acc};
        end
    end

    cab_regfile u_rf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd0    (rf_rd0),
        .i_rd1    (rf_rd1),
        .i_wr     (rf_wr),
        .o_rdata0 (rd0),
        .o_rdata1 (rd1)
    );

    assign div_sh = {r_acc[WORD_W-2:0], r_quo[WORD_W-1]};

    // operand select for the shared adder
    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        case (r_state)
            S_EXEC: begin
                case (r_mode)
                    OP_ADD: begin add_a = r_x; add_b = r_y; end
                    OP_ADC: begin add_a = r_x; add_b = r_y; add_cin = r_carry; end
                    OP_SUB: begin add_a = r_x; add_b = ~r_y; add_cin = 1'b1; end
                    OP_SBB: begin add_a = r_x; add_b = ~r_y; add_cin = !r_carry; end
                    OP_INC, OP_FOR: begin add_a = ra; add_cin = 1'b1; end
                    OP_DEC: begin add_a = ra; add_b = '1; end
                    OP_NEG: begin add_b = ~r_x; add_cin = 1'b1; end
                    OP_JZ, OP_JNZ: begin add_a = ra; add_b = '1; add_cin = 1'b1; end
                    OP_JL, OP_JLE, OP_JG, OP_JGE: begin
                        add_a   = ra ^ sign_bit;
                        add_b   = ~(r_x ^ sign_bit);
                        add_cin = 1'b1;
                    end
                    default: begin add_a = ra; add_b = ~r_x; add_cin = 1'b1; end
                endcase
            end
            S_MUL: begin
                add_a = {r_acc[WORD_W-2:0], 1'b0};
                add_b = r_y[WORD_W-1] ? r_x : '0;
            end
            S_DIV: begin add_a = div_sh; add_b = ~r_y; add_cin = 1'b1; end
            S_FOR: begin
                add_a   = a_ok ? r_wval : '0;
                add_b   = ~r_b;
                add_cin = 1'b1;
            end
            default: ;
        endcase
    end

    cab_addsub u_add (
        .i_a   (add_a),
        .i_b   (add_b),
        .i_cin (add_cin),
        .o_res (add_res)
    );

    assign lt     = !add_res.cout;
    assign eq     = add_res.zero;
    assign div_ge = r_acc[WORD_W-1] || add_res.cout;

    always_comb begin
        case (r_mode)
            OP_JE:  cond = eq;
            OP_JNE: cond = !eq;
            OP_JZ:  cond = eq;
            OP_JNZ: cond = !eq;
            OP_JL, OP_JB:   cond = lt;
            OP_JLE, OP_JBE: cond = lt || eq;
            OP_JG, OP_JA:   cond = !(lt || eq);
            OP_JGE, OP_JAE: cond = !lt;
            default: cond = 1'b0;
        endcase
    end

    always_comb begin
        case (r_mode)
            OP_SHL:  shf = c_big ? '0 : (r_x << r_c[CNT_W-1:0]);
            OP_SHR:  shf = c_big ? '0 : (r_x >> r_c[CNT_W-1:0]);
            default: shf = c_big ? {WORD_W{r_x[WORD_W-1]}}
                                 : WORD_W'($signed(r_x) >>> r_c[CNT_W-1:0]);
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (s_acc) n_state = S_RDBC;
            S_RDBC: n_state = S_RDA;
            S_RDA:  n_state = S_EXEC;
            S_EXEC: begin
                case (r_mode)
                    OP_MUL:  n_state = S_MUL;
                    OP_DIV:  n_state = (r_y == '0) ? S_WB : S_DIV;
                    OP_FOR:  n_state = S_FOR;
                    OP_SWP:  n_state = S_SWP;
                    default: n_state = S_WB;
                endcase
            end
            S_MUL, S_DIV: if (r_cnt == '0) n_state = S_WB;
            S_FOR, S_SWP: n_state = S_WB;
            S_WB:   if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_carry     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_EXEC) begin
                case (r_mode)
                    OP_ADD, OP_ADC: r_carry <= add_res.cout;
                    OP_SUB, OP_SBB: r_carry <= !add_res.cout;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_mode <= i_s_axis_tuser;
                r_a    <= i_s_axis_tdata[WORD_W-1:0];
                r_b    <= i_s_axis_tdata[2*WORD_W-1:WORD_W];
                r_c    <= i_s_axis_tdata[3*WORD_W-1:2*WORD_W];
            end
            S_RDA: begin
                r_x <= rd0;
                r_y <= rd1;
            end
            S_EXEC: begin
                r_wen  <= 1'b0;
                r_widx <= r_a[IDX_W-1:0];
                r_wval <= '0;
                r_take <= 1'b0;
                r_tgt  <= '0;
                r_halt <= 1'b0;
                r_acc  <= '0;
                r_quo  <= r_x;
                r_cnt  <= '1;
                case (r_mode)
                    OP_LOD: begin r_wen <= a_ok; r_wval <= r_b; end
                    OP_SWP: begin r_wen <= a_ok; r_wval <= r_x; r_acc <= ra; end
                    OP_ADD, OP_ADC, OP_SUB, OP_SBB, OP_INC, OP_DEC, OP_NEG,
                    OP_FOR: begin
                        r_wen  <= a_ok;
                        r_wval <= add_res.sum;
                    end
                    OP_MUL, OP_DIV: r_wen <= a_ok;
                    OP_AND: begin r_wen <= a_ok; r_wval <= r_x & r_y; end
                    OP_OR:  begin r_wen <= a_ok; r_wval <= r_x | r_y; end
                    OP_XOR: begin r_wen <= a_ok; r_wval <= r_x ^ r_y; end
                    OP_NOT: begin r_wen <= a_ok; r_wval <= ~r_x; end
                    OP_SHL, OP_SHR, OP_SAR: begin r_wen <= a_ok; r_wval <= shf; end
                    OP_JMP: begin r_take <= 1'b1; r_tgt <= r_a; end
                    OP_JZ, OP_JNZ: begin
                        r_take <= cond;
                        r_tgt  <= cond ? r_b : '0;
                    end
                    OP_JE, OP_JNE, OP_JL, OP_JLE, OP_JG, OP_JGE,
                    OP_JB, OP_JBE, OP_JA, OP_JAE: begin
                        r_take <= cond;
                        r_tgt  <= cond ? r_c : '0;
                    end
                    OP_BRK: r_halt <= 1'b1;
                    default: ;
                endcase
            end
            S_MUL: begin
                r_acc <= add_res.sum;
                r_y   <= {r_y[WORD_W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) r_wval <= add_res.sum;
            end
            S_DIV: begin
                r_acc <= div_ge ? add_res.sum : div_sh;
                r_quo <= {r_quo[WORD_W-2:0], div_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) r_wval <= {r_quo[WORD_W-2:0], div_ge};
            end
            S_FOR: begin
                r_take <= lt;
                r_tgt  <= lt ? r_c : '0;
            end
            S_WB: begin
                if (out_load) begin
                    r_out_data <= {r_halt, r_carry, r_tgt, r_take,
                                   r_wen ? r_wval : {WORD_W{1'b0}},
                                   r_wen ? r_widx : {IDX_W{1'b0}}, r_wen};
                end
            end
            default: ;
        endcase
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_y != '0))
        else $error("divide sequence entered with zero divisor");

    a_halt_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_data[39] && (r_out_data[0] || r_out_data[21])))
        else $error("halt result also writes or branches");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_data[0]) |-> (r_out_data[20:1] == '0))
        else $error("write fields nonzero without write enable");

    a_no_branch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_data[21]) |-> (r_out_data[37:22] == '0))
        else $error("branch target nonzero without branch");

    a_load_from_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_WB))
        else $error("result posted outside write-back");

endmodule

`default_nettype wire
